// File: rtl/rssp_pkg.sv
// ----------------------------------------------------------------------------
// rssp_pkg
// Shared widths, constants and request types of the ray/sphere surface unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rssp_pkg;

	localparam int DIR_FRAC_BITS = 30;

	localparam int POS_W = 28;
	localparam int DIR_W = 32;
	localparam int RAD_W = 26;

	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(6378137);

	// front end: dot product, squared length, discriminant
	localparam int PD_W   = POS_W + DIR_W;
	localparam int B_W    = PD_W + 2;
	localparam int PP_W   = 2 * POS_W;
	localparam int MAG2_W = PP_W + 2;
	localparam int R2_W   = 2 * RAD_W;
	localparam int C_W    = MAG2_W + 1;
	localparam int BH_W   = B_W / 2;
	localparam int HH_W   = 2 * BH_W;
	localparam int DISC_W = 2 * B_W;

	// square root
	localparam int ROOT_W = B_W;

	// back end: root times direction
	localparam int T_W    = B_W + 2;
	localparam int TH_W   = T_W / 2;
	localparam int PH_W   = TH_W + DIR_W;
	localparam int PROD_W = T_W + DIR_W;
	localparam int STEP_W = PROD_W + 1 - 2 * DIR_FRAC_BITS;
	localparam int SUM_W  = STEP_W + 2;

	localparam logic signed [POS_W-1:0] SURF_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] SURF_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [DIR_W-1:0] DIR_MAX  = {1'b0, {(DIR_W-1){1'b1}}};
	localparam logic signed [DIR_W-1:0] DIR_MIN  = {1'b1, {(DIR_W-1){1'b0}}};

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic                    hit;
		logic                    started_outside;
		logic signed [POS_W-1:0] surf_x;
		logic signed [POS_W-1:0] surf_y;
		logic signed [POS_W-1:0] surf_z;
		logic signed [DIR_W-1:0] out_dir_x;
		logic signed [DIR_W-1:0] out_dir_y;
		logic signed [DIR_W-1:0] out_dir_z;
	} result_t;

	typedef struct packed {
		logic signed [B_W-1:0] b;
		logic                  hit;
		logic                  outside;
		ray_t                  ray;
	} side_t;

	typedef struct packed {
		logic [DISC_W-1:0] disc;
		side_t             side;
	} disc_req_t;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		side_t             side;
	} root_req_t;

endpackage

`default_nettype wire

// File: rtl/ray_sphere_surface_point_unit.sv
// Pipeline stages from request acceptance to result valid: 6 front, 62 root, 5 back.
// Throughput: one request per cycle while results are taken; the 62-stage bit-per-stage square root sets the depth.
// A held result stalls only stages that are full; empty stages still fill behind it.
// Reset (arst_n low, asynchronous) empties every stage and loads the radius 6378137 m.
// ----------------------------------------------------------------------------
// ray_sphere_surface_point_unit
// Surface point where a line from a start point meets a centred sphere.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_surface_point_unit import rssp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [RAD_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  ray_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          out_data
);

	// sphere radius; the user must write it only while the unit is idle, the block does not enforce this
	logic [RAD_W-1:0] sphere_radius_q;

	// front end to root extractor
	logic      fr_valid, fr_ready;
	disc_req_t fr_data;

	// root extractor to back end
	logic      sq_valid, sq_ready;
	root_req_t sq_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			sphere_radius_q <= cfg_wdata;
		end
	end

	// b = d.p, c = |p|^2 - R^2, discriminant b^2 - c and the hit decision
	rssp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sphere_radius (sphere_radius_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (fr_valid),
		.out_ready     (fr_ready),
		.out_data      (fr_data)
	);

	// floor square root of the discriminant, one bit per stage
	rssp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_data),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.out_data  (sq_data)
	);

	// choose root, scale direction, round half away from zero, saturate
	rssp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_ready  (sq_ready),
		.in_data   (sq_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// input can only be held off by a full pipeline behind a waiting result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input held off without a stalled result");

	// a miss needs c > 0, so the start point lies outside
	a_miss_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |-> out_data.started_outside)
		else $error("miss reported for a start point inside the sphere");

	// a miss carries a zero surface point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |->
		(out_data.surf_x == '0 && out_data.surf_y == '0 && out_data.surf_z == '0))
		else $error("miss with non-zero surface point");

endmodule

`default_nettype wire

// File: rtl/rssp_front.sv
// ----------------------------------------------------------------------------
// rssp_front
// Six-stage front end: forms b, c, b^2 and the discriminant with the hit flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rssp_front import rssp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [RAD_W-1:0] sphere_radius,
	input  logic             in_valid,
	output logic             in_ready,
	input  ray_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output disc_req_t        out_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	logic signed [POS_W-1:0] pos_in [3];
	logic signed [DIR_W-1:0] dir_in [3];
	logic signed [PD_W-1:0]  pd_c   [3];
	logic signed [PP_W-1:0]  pp_c   [3];

	logic signed [PD_W-1:0] pd_s1 [3];
	logic [PP_W-1:0]        pp_s1 [3];
	logic [R2_W-1:0]        r2_s1;
	ray_t                   ray_s1;

	logic [MAG2_W-1:0]     mag2_c;
	logic signed [B_W-1:0] b_s2;
	logic signed [C_W-1:0] c_s2;
	logic                  outside_s2;
	ray_t                  ray_s2;

	logic [B_W-1:0]        bmag_s3;
	logic [C_W-1:0]        cmag_s3;
	logic                  cneg_s3, outside_s3;
	logic signed [B_W-1:0] b_s3;
	ray_t                  ray_s3;

	logic [HH_W-1:0]       hh_s4, hl_s4, ll_s4;
	logic [C_W-1:0]        cmag_s4;
	logic                  cneg_s4, outside_s4;
	logic signed [B_W-1:0] b_s4;
	ray_t                  ray_s4;

	logic [DISC_W-1:0]     bsq_s5, cs_s5;
	logic                  cneg_s5, outside_s5;
	logic signed [B_W-1:0] b_s5;
	ray_t                  ray_s5;

	logic [DISC_W-1:0]     disc_s6;
	logic                  hit_s6, outside_s6;
	logic signed [B_W-1:0] b_s6;
	ray_t                  ray_s6;

	// advance a stage when it is empty or the next one moves
	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_comb begin
		pos_in[0] = in_data.pos_x;
		pos_in[1] = in_data.pos_y;
		pos_in[2] = in_data.pos_z;
		dir_in[0] = in_data.dir_x;
		dir_in[1] = in_data.dir_y;
		dir_in[2] = in_data.dir_z;
		for (int k = 0; k < 3; k++) begin
			pd_c[k] = PD_W'(pos_in[k]) * PD_W'(dir_in[k]);
			pp_c[k] = PP_W'(pos_in[k]) * PP_W'(pos_in[k]);
		end
	end

	assign mag2_c = MAG2_W'(pp_s1[0]) + MAG2_W'(pp_s1[1]) + MAG2_W'(pp_s1[2]);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int k = 0; k < 3; k++) begin
				pd_s1[k] <= pd_c[k];
				pp_s1[k] <= $unsigned(pp_c[k]);
			end
			r2_s1  <= R2_W'(sphere_radius) * R2_W'(sphere_radius);
			ray_s1 <= in_data;
		end
		if (en_s2) begin
			b_s2       <= B_W'(pd_s1[0]) + B_W'(pd_s1[1]) + B_W'(pd_s1[2]);
			c_s2       <= $signed(C_W'(mag2_c)) - $signed(C_W'(r2_s1));
			outside_s2 <= mag2_c > MAG2_W'(r2_s1);
			ray_s2     <= ray_s1;
		end
		if (en_s3) begin
			bmag_s3    <= b_s2[B_W-1] ? $unsigned(-b_s2) : $unsigned(b_s2);
			cmag_s3    <= c_s2[C_W-1] ? $unsigned(-c_s2) : $unsigned(c_s2);
			cneg_s3    <= c_s2[C_W-1];
			outside_s3 <= outside_s2;
			b_s3       <= b_s2;
			ray_s3     <= ray_s2;
		end
		if (en_s4) begin
			// b^2 from half-width partial products
			hh_s4      <= HH_W'(bmag_s3[B_W-1:BH_W]) * HH_W'(bmag_s3[B_W-1:BH_W]);
			hl_s4      <= HH_W'(bmag_s3[B_W-1:BH_W]) * HH_W'(bmag_s3[BH_W-1:0]);
			ll_s4      <= HH_W'(bmag_s3[BH_W-1:0]) * HH_W'(bmag_s3[BH_W-1:0]);
			cmag_s4    <= cmag_s3;
			cneg_s4    <= cneg_s3;
			outside_s4 <= outside_s3;
			b_s4       <= b_s3;
			ray_s4     <= ray_s3;
		end
		if (en_s5) begin
			bsq_s5     <= (DISC_W'(hh_s4) << (2 * BH_W)) + (DISC_W'(hl_s4) << (BH_W + 1))
				+ DISC_W'(ll_s4);
			cs_s5      <= DISC_W'(cmag_s4) << (2 * DIR_FRAC_BITS);
			cneg_s5    <= cneg_s4;
			outside_s5 <= outside_s4;
			b_s5       <= b_s4;
			ray_s5     <= ray_s4;
		end
		if (en_s6) begin
			if (cneg_s5) begin
				disc_s6 <= bsq_s5 + cs_s5;
				hit_s6  <= 1'b1;
			end else begin
				disc_s6 <= bsq_s5 - cs_s5;
				hit_s6  <= bsq_s5 >= cs_s5;
			end
			outside_s6 <= outside_s5;
			b_s6       <= b_s5;
			ray_s6     <= ray_s5;
		end
	end

	assign out_valid            = v_s6;
	assign out_data.disc         = disc_s6;
	assign out_data.side.b       = b_s6;
	assign out_data.side.hit     = hit_s6;
	assign out_data.side.outside = outside_s6;
	assign out_data.side.ray     = ray_s6;

endmodule

`default_nettype wire

// File: rtl/rssp_sqrt.sv
// ----------------------------------------------------------------------------
// rssp_sqrt
// Pipelined restoring square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rssp_sqrt import rssp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  disc_req_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output root_req_t out_data
);

	logic              v_s    [ROOT_W];
	logic              en     [ROOT_W];
	logic [DISC_W-1:0] rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	side_t             side_s [ROOT_W];

	logic              v_in    [ROOT_W];
	logic [DISC_W-1:0] rem_in  [ROOT_W];
	logic [ROOT_W-1:0] root_in [ROOT_W];
	side_t             side_in [ROOT_W];
	logic [DISC_W:0]   trial   [ROOT_W];
	logic              fits    [ROOT_W];

	always_comb begin
		v_in[0]    = in_valid;
		rem_in[0]  = in_data.disc;
		root_in[0] = '0;
		side_in[0] = in_data.side;
		for (int g = 1; g < ROOT_W; g++) begin
			v_in[g]    = v_s[g-1];
			rem_in[g]  = rem_s[g-1];
			root_in[g] = root_s[g-1];
			side_in[g] = side_s[g-1];
		end
		en[ROOT_W-1] = !v_s[ROOT_W-1] || out_ready;
		for (int g = ROOT_W - 2; g >= 0; g--) begin
			en[g] = !v_s[g] || en[g+1];
		end
		// stage g decides root bit ROOT_W-1-g: (2q + 2^i) * 2^i against remainder
		for (int g = 0; g < ROOT_W; g++) begin
			trial[g] = ((DISC_W+1)'(root_in[g]) << (ROOT_W - g))
				| ((DISC_W+1)'(1) << (2 * (ROOT_W - 1 - g)));
			fits[g]  = {1'b0, rem_in[g]} >= trial[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < ROOT_W; g++) v_s[g] <= 1'b0;
		end else begin
			for (int g = 0; g < ROOT_W; g++) begin
				if (en[g]) v_s[g] <= v_in[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < ROOT_W; g++) begin
			if (en[g]) begin
				rem_s[g]  <= fits[g] ? DISC_W'({1'b0, rem_in[g]} - trial[g]) : rem_in[g];
				root_s[g] <= fits[g] ? (root_in[g] | (ROOT_W'(1) << (ROOT_W - 1 - g)))
					: root_in[g];
				side_s[g] <= side_in[g];
			end
		end
	end

	assign in_ready      = en[0];
	assign out_valid     = v_s[ROOT_W-1];
	assign out_data.root = root_s[ROOT_W-1];
	assign out_data.side = side_s[ROOT_W-1];

endmodule

`default_nettype wire

// File: rtl/rssp_back.sv
// ----------------------------------------------------------------------------
// rssp_back
// Five-stage back end: root choice, t times direction, rounding, saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rssp_back import rssp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  root_req_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   out_data
);

	function automatic logic signed [DIR_W-1:0] neg_sat(input logic signed [DIR_W-1:0] d);
		return (d == DIR_MIN) ? DIR_MAX : -d;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic signed [T_W-1:0] t_s1;
	side_t                 side_s1, side_s2, side_s3, side_s4;

	logic signed [POS_W-1:0] pos_s [3];
	logic signed [DIR_W-1:0] dir_s [3];

	logic [T_W-1:0]   tmag_s2;
	logic [DIR_W-1:0] dmag_s2 [3];
	logic             neg_s2  [3];

	logic [PH_W-1:0] plo_s3 [3];
	logic [PH_W-1:0] phi_s3 [3];
	logic            neg_s3 [3];

	logic [PROD_W:0]   prod_c [3];
	logic [STEP_W-1:0] q_s4   [3];
	logic              neg_s4 [3];

	logic signed [T_W-1:0]   s_c;
	logic signed [T_W-1:0]   b_c;
	logic signed [SUM_W-1:0] step_c [3];
	logic signed [SUM_W-1:0] sum_c  [3];
	logic signed [POS_W-1:0] sat_c  [3];
	logic signed [POS_W-1:0] pos4_c [3];
	logic signed [DIR_W-1:0] dir4_c [3];
	logic signed [DIR_W-1:0] odir_c [3];
	result_t                 res_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	assign s_c = $signed(T_W'(in_data.root));
	assign b_c = T_W'(in_data.side.b);

	always_comb begin
		dir_s[0] = side_s1.ray.dir_x;
		dir_s[1] = side_s1.ray.dir_y;
		dir_s[2] = side_s1.ray.dir_z;
		pos4_c[0] = side_s4.ray.pos_x;
		pos4_c[1] = side_s4.ray.pos_y;
		pos4_c[2] = side_s4.ray.pos_z;
		dir4_c[0] = side_s4.ray.dir_x;
		dir4_c[1] = side_s4.ray.dir_y;
		dir4_c[2] = side_s4.ray.dir_z;
		for (int k = 0; k < 3; k++) begin
			pos_s[k]  = pos4_c[k];
			prod_c[k] = ((PROD_W+1)'(phi_s3[k]) << TH_W) + (PROD_W+1)'(plo_s3[k])
				+ ((PROD_W+1)'(1) << (2 * DIR_FRAC_BITS - 1));
			step_c[k] = $signed(SUM_W'(q_s4[k]));
			if (neg_s4[k]) step_c[k] = -step_c[k];
			sum_c[k] = SUM_W'(pos_s[k]) + step_c[k];
			if (sum_c[k] > SUM_W'(SURF_MAX)) begin
				sat_c[k] = SURF_MAX;
			end else if (sum_c[k] < SUM_W'(SURF_MIN)) begin
				sat_c[k] = SURF_MIN;
			end else begin
				sat_c[k] = POS_W'(sum_c[k]);
			end
			if (!side_s4.hit) sat_c[k] = '0;
			odir_c[k] = (side_s4.hit && side_s4.outside) ? neg_sat(dir4_c[k]) : dir4_c[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			// outside start takes the far root, inside the near one
			t_s1    <= in_data.side.outside ? (s_c - b_c) : (-b_c - s_c);
			side_s1 <= in_data.side;
		end
		if (en_s2) begin
			tmag_s2 <= t_s1[T_W-1] ? $unsigned(-t_s1) : $unsigned(t_s1);
			for (int k = 0; k < 3; k++) begin
				dmag_s2[k] <= dir_s[k][DIR_W-1] ? $unsigned(-dir_s[k]) : $unsigned(dir_s[k]);
				neg_s2[k]  <= t_s1[T_W-1] ^ dir_s[k][DIR_W-1];
			end
			side_s2 <= side_s1;
		end
		if (en_s3) begin
			for (int k = 0; k < 3; k++) begin
				plo_s3[k] <= PH_W'(tmag_s2[TH_W-1:0]) * PH_W'(dmag_s2[k]);
				phi_s3[k] <= PH_W'(tmag_s2[T_W-1:TH_W]) * PH_W'(dmag_s2[k]);
				neg_s3[k] <= neg_s2[k];
			end
			side_s3 <= side_s2;
		end
		if (en_s4) begin
			for (int k = 0; k < 3; k++) begin
				q_s4[k]   <= STEP_W'(prod_c[k] >> (2 * DIR_FRAC_BITS));
				neg_s4[k] <= neg_s3[k];
			end
			side_s4 <= side_s3;
		end
		if (en_s5) begin
			res_s5.hit             <= side_s4.hit;
			res_s5.started_outside <= side_s4.outside;
			res_s5.surf_x          <= sat_c[0];
			res_s5.surf_y          <= sat_c[1];
			res_s5.surf_z          <= sat_c[2];
			res_s5.out_dir_x       <= odir_c[0];
			res_s5.out_dir_y       <= odir_c[1];
			res_s5.out_dir_z       <= odir_c[2];
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

endmodule

`default_nettype wire
